// ----- src/plth_pkg.sv -----
`default_nettype none

package plth_pkg;

  // Shared serial multiply/divide unit sizing.
  localparam int unsigned MUL_CYCLES = 16;
  localparam int unsigned DIV_CYCLES = 32;
  localparam int unsigned CNT_W      = $clog2(DIV_CYCLES);
  localparam int unsigned WORK_W     = DIV_CYCLES;
  localparam int unsigned MPLR_W     = MUL_CYCLES;
  localparam int unsigned DVSR_W     = 20;

  // Stream and configuration port widths.
  localparam int unsigned S_TDATA_W  = 88;
  localparam int unsigned M_TDATA_W  = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_WB,
    ST_DONE
  } state_e;

  // Micro-operations, each one (a * b) / c on the shared unit.
  typedef enum logic [3:0] {
    OP_RATED,
    OP_BATT_MW,
    OP_BATT_W,
    OP_SENSE_I,
    OP_VOLT,
    OP_ADPT_RAW,
    OP_ADPT_MW,
    OP_TOTAL_W,
    OP_THR_ASSERT,
    OP_THR_RELEASE
  } op_e;

  // Reported action codes.
  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_ASSERT,
    ACT_RELEASE,
    ACT_SKIP
  } action_e;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SENSE_R      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATING       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BATT_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BATT_ASSERT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BATT_RELEASE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RATED_ASSERT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_RATED_RELEASE = 3'd7;

  // Configuration reset values.
  localparam logic [6:0] RST_SENSE_R       = 7'd10;
  localparam logic [7:0] RST_RATING        = 8'd60;
  localparam logic [7:0] RST_BATT_MAX      = 8'd50;
  localparam logic [7:0] RST_GAIN          = 8'd100;
  localparam logic [7:0] RST_BATT_ASSERT   = 8'd95;
  localparam logic [7:0] RST_BATT_RELEASE  = 8'd85;
  localparam logic [7:0] RST_RATED_ASSERT  = 8'd100;
  localparam logic [7:0] RST_RATED_RELEASE = 8'd90;

  // Fixed threshold percentages.
  localparam logic [7:0] RATED_BATT_RELEASE_PCT   = 8'd90;
  localparam logic [7:0] ADAPTER_ASSERT_PCT       = 8'd100;
  localparam logic [7:0] ADAPTER_RELEASE_PCT      = 8'd90;
  localparam logic [7:0] ADAPTER_BATT_RELEASE_PCT = 8'd90;
  localparam logic [7:0] PCT_SCALE                = 8'd100;

  // Other constants.
  localparam logic [6:0]        SOC_LOW_PCT = 7'd10;
  localparam logic [MPLR_W-1:0] SENSE_GAIN  = 16'd25;
  localparam logic [MPLR_W-1:0] MPLR_ONE    = 16'd1;
  localparam logic [DVSR_W-1:0] DIV_ONE     = 20'd1;
  localparam logic [DVSR_W-1:0] DIV_PCT     = 20'd100;
  localparam logic [DVSR_W-1:0] DIV_MILLI   = 20'd1000;
  localparam logic [DVSR_W-1:0] DIV_MICRO   = 20'd1000000;

endpackage

`default_nettype wire

// ----- src/power_limit_throttle_hysteresis_core.sv -----
// Each sample runs ten operations on one shared bit-serial unit (16 multiply
// steps plus 32 divide steps, plus load and write-back), one operation after
// another; a new sample is accepted only after the result of the last one has
// been loaded into the output register.
// Reset (rst_ni low, asynchronous): throttle released, configuration at its
// default values, no result pending.
`default_nettype none

module power_limit_throttle_hysteresis_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Sample input stream.
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // From bit 0: adapter_sense_mv[12], adapter_voltage_mv[16],
  // adapter_current_ma[16], battery_voltage_mv[16], battery_current_ma[16],
  // charge_percent[7], battery_read_failed, charger_setup_failed,
  // ac_present, battery_present, one zero pad bit.
  input  wire logic [plth_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // Result output stream.
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // From bit 0: throttle_active, action[2], system_power_w[16],
  // current_limit_enable, four zero pad bits.
  output logic [plth_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  // Configuration write channel.
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [plth_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [plth_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  // Configuration registers.
  logic [6:0] cfg_sense_r_q;
  logic [7:0] cfg_rating_q;
  logic [7:0] cfg_bmax_q;
  logic [7:0] cfg_gain_q;
  logic [7:0] cfg_ba_q;
  logic [7:0] cfg_br_q;
  logic [7:0] cfg_ra_q;
  logic [7:0] cfg_rr_q;

  // Sequencer control.
  plth_pkg::state_e state_q, state_d;
  plth_pkg::op_e    op_q;
  logic [plth_pkg::CNT_W-1:0] cnt_q;
  logic in_xfer;
  logic out_load;

  // Captured sample.
  logic [11:0] in_sense_q;
  logic [15:0] in_avolt_q;
  logic [15:0] in_acur_q;
  logic [15:0] in_bvolt_q;
  logic [15:0] in_bcur_q;
  logic [6:0]  in_soc_q;
  logic        in_bfail_q;
  logic        in_cfail_q;
  logic        in_ac_q;
  logic        in_bpres_q;

  // Intermediate results.
  logic [12:0] rated_w_q;
  logic [21:0] batt_mw_q;
  logic [11:0] batt_w_q;
  logic [16:0] sense_i_q;
  logic [6:0]  volt_v_q;
  logic [22:0] adpt_raw_q;
  logic [24:0] adpt_mw_q;
  logic [14:0] total_w_q;
  logic [15:0] thr_a_q;
  logic [15:0] thr_r_q;

  // Serial unit registers.
  logic [plth_pkg::WORK_W-1:0] work_q;
  logic [plth_pkg::WORK_W-1:0] mcand_q;
  logic [plth_pkg::MPLR_W-1:0] mplier_q;
  logic [plth_pkg::DVSR_W-1:0] dvsr_q;
  logic [plth_pkg::DVSR_W-1:0] rem_q;

  // Output register and throttle level.
  logic              out_valid_q;
  logic              out_throttle_q;
  plth_pkg::action_e out_action_q;
  logic [15:0]       out_power_q;
  logic              out_cle_q;
  logic              throttle_q;

  // Derived sample values.
  logic        bcur_neg;
  logic [15:0] bmag;
  logic        low_batt;
  logic        rated_ge;
  logic        skip;
  logic [21:0] batt_add;
  logic [25:0] total_mw;
  logic [6:0]  r_eff;

  // Threshold setup.
  logic [13:0] thr_xa;
  logic [13:0] thr_xr;
  logic [7:0]  thr_pa;
  logic [7:0]  thr_pr;
  logic [15:0] thr_add;

  // Operand selection.
  logic [plth_pkg::WORK_W-1:0] opa;
  logic [plth_pkg::MPLR_W-1:0] opb;
  logic [plth_pkg::DVSR_W-1:0] opc;

  // Serial step values.
  logic [plth_pkg::WORK_W-1:0] mul_sum;
  logic [plth_pkg::DVSR_W:0]   div_shift;
  logic [plth_pkg::DVSR_W:0]   div_diff;
  logic                        div_ge;

  // Decision.
  logic [15:0]       cmp_val;
  logic              rel_hit;
  plth_pkg::action_e action_c;
  logic              level_next;

  // Values derived from the captured sample.
  always_comb begin
    bcur_neg = in_bcur_q[15];
    bmag     = bcur_neg ? (16'd0 - in_bcur_q) : in_bcur_q;
    low_batt = !in_bpres_q || (in_soc_q <= plth_pkg::SOC_LOW_PCT);
    rated_ge = rated_w_q >= {5'd0, cfg_rating_q};
    skip     = in_cfail_q || (in_bfail_q && !in_ac_q);
    batt_add = (bcur_neg && (batt_mw_q != 22'd0)) ? batt_mw_q : 22'd0;
    total_mw = {1'b0, adpt_mw_q} + {4'd0, batt_add};
    r_eff    = (cfg_sense_r_q == 7'd0) ? 7'd1 : cfg_sense_r_q;
  end

  // Pick the threshold operands of the rule that applies.
  always_comb begin
    thr_xa  = {6'd0, cfg_bmax_q};
    thr_xr  = {6'd0, cfg_bmax_q};
    thr_pa  = cfg_ba_q;
    thr_pr  = cfg_br_q;
    thr_add = 16'd0;
    if (in_ac_q) begin
      if (rated_ge) begin
        if (low_batt) begin
          thr_xa = {6'd0, cfg_rating_q};
          thr_xr = {6'd0, cfg_rating_q};
          thr_pa = cfg_ra_q;
          thr_pr = cfg_rr_q;
        end else begin
          thr_xa = {6'd0, cfg_rating_q} + {6'd0, cfg_bmax_q};
          thr_xr = {6'd0, cfg_rating_q} + {6'd0, cfg_bmax_q};
          thr_pa = plth_pkg::PCT_SCALE;
          thr_pr = plth_pkg::RATED_BATT_RELEASE_PCT;
        end
      end else begin
        if (low_batt) begin
          thr_xa = {1'b0, rated_w_q};
          thr_xr = {1'b0, rated_w_q};
          thr_pa = plth_pkg::ADAPTER_ASSERT_PCT;
          thr_pr = plth_pkg::ADAPTER_RELEASE_PCT;
        end else begin
          thr_xa  = {1'b0, rated_w_q} + {6'd0, cfg_bmax_q};
          thr_xr  = {6'd0, cfg_bmax_q};
          thr_pa  = plth_pkg::PCT_SCALE;
          thr_pr  = plth_pkg::ADAPTER_BATT_RELEASE_PCT;
          thr_add = {3'd0, rated_w_q};
        end
      end
    end
  end

  // Operands of the current operation: result = (opa * opb) / opc.
  always_comb begin
    opa = {16'd0, in_avolt_q};
    opb = plth_pkg::MPLR_ONE;
    opc = plth_pkg::DIV_MILLI;
    case (op_q)
      plth_pkg::OP_RATED: begin
        opa = {16'd0, in_acur_q};
        opb = in_avolt_q;
        opc = plth_pkg::DIV_MICRO;
      end
      plth_pkg::OP_BATT_MW: begin
        opa = {16'd0, in_bvolt_q};
        opb = bmag;
        opc = plth_pkg::DIV_MILLI;
      end
      plth_pkg::OP_BATT_W: begin
        opa = {10'd0, batt_mw_q};
        opb = plth_pkg::MPLR_ONE;
        opc = plth_pkg::DIV_MILLI;
      end
      plth_pkg::OP_SENSE_I: begin
        opa = {20'd0, in_sense_q};
        opb = plth_pkg::SENSE_GAIN;
        opc = {13'd0, r_eff};
      end
      plth_pkg::OP_VOLT: begin
        opa = {16'd0, in_avolt_q};
        opb = plth_pkg::MPLR_ONE;
        opc = plth_pkg::DIV_MILLI;
      end
      plth_pkg::OP_ADPT_RAW: begin
        opa = {15'd0, sense_i_q};
        opb = {9'd0, volt_v_q};
        opc = plth_pkg::DIV_ONE;
      end
      plth_pkg::OP_ADPT_MW: begin
        opa = {9'd0, adpt_raw_q};
        opb = {8'd0, cfg_gain_q};
        opc = plth_pkg::DIV_PCT;
      end
      plth_pkg::OP_TOTAL_W: begin
        opa = {6'd0, total_mw};
        opb = plth_pkg::MPLR_ONE;
        opc = plth_pkg::DIV_MILLI;
      end
      plth_pkg::OP_THR_ASSERT: begin
        opa = {18'd0, thr_xa};
        opb = {8'd0, thr_pa};
        opc = plth_pkg::DIV_PCT;
      end
      plth_pkg::OP_THR_RELEASE: begin
        opa = {18'd0, thr_xr};
        opb = {8'd0, thr_pr};
        opc = plth_pkg::DIV_PCT;
      end
      default: begin
        opa = {16'd0, in_avolt_q};
        opb = plth_pkg::MPLR_ONE;
        opc = plth_pkg::DIV_MILLI;
      end
    endcase
  end

  // One multiplier bit or one quotient bit per cycle. Products stay
  // within 32 bits for every operation in the sequence.
  always_comb begin
    mul_sum   = work_q + (mplier_q[0] ? mcand_q : '0);
    div_shift = {rem_q, work_q[plth_pkg::WORK_W-1]};
    div_ge    = div_shift >= {1'b0, dvsr_q};
    div_diff  = div_shift - {1'b0, dvsr_q};
  end

  // Threshold rules. Total watts never exceed 15 bits here, so the
  // saturated output is the plain zero-extended value.
  always_comb begin
    cmp_val = in_ac_q ? {1'b0, total_w_q} : {4'd0, batt_w_q};
    rel_hit = (in_ac_q && low_batt) ? (cmp_val <= thr_r_q) : (cmp_val < thr_r_q);
    if (skip) begin
      action_c = plth_pkg::ACT_SKIP;
    end else if (!in_ac_q && !in_bpres_q) begin
      action_c = plth_pkg::ACT_RELEASE;
    end else if (cmp_val > thr_a_q) begin
      action_c = plth_pkg::ACT_ASSERT;
    end else if (rel_hit) begin
      action_c = plth_pkg::ACT_RELEASE;
    end else begin
      action_c = plth_pkg::ACT_HOLD;
    end
    case (action_c)
      plth_pkg::ACT_ASSERT:  level_next = 1'b1;
      plth_pkg::ACT_RELEASE: level_next = 1'b0;
      default:               level_next = throttle_q;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      plth_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = plth_pkg::ST_LOAD;
      end
      plth_pkg::ST_LOAD: state_d = plth_pkg::ST_MUL;
      plth_pkg::ST_MUL: begin
        if (cnt_q == plth_pkg::CNT_W'(plth_pkg::MUL_CYCLES - 1)) state_d = plth_pkg::ST_DIV;
      end
      plth_pkg::ST_DIV: begin
        if (cnt_q == plth_pkg::CNT_W'(plth_pkg::DIV_CYCLES - 1)) state_d = plth_pkg::ST_WB;
      end
      plth_pkg::ST_WB: begin
        state_d = (op_q == plth_pkg::OP_THR_RELEASE) ? plth_pkg::ST_DONE : plth_pkg::ST_LOAD;
      end
      plth_pkg::ST_DONE: begin
        if (out_load) state_d = plth_pkg::ST_IDLE;
      end
      default: state_d = plth_pkg::ST_IDLE;
    endcase
  end

  // State machine outputs.
  always_comb begin
    s_axis_tready = (state_q == plth_pkg::ST_IDLE);
    in_xfer       = s_axis_tvalid && s_axis_tready;
    out_load      = (state_q == plth_pkg::ST_DONE) && (!out_valid_q || m_axis_tready);
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_cle_q, out_power_q, out_action_q, out_throttle_q};

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= plth_pkg::ST_IDLE;
      op_q          <= plth_pkg::OP_RATED;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      throttle_q    <= 1'b0;
      cfg_sense_r_q <= plth_pkg::RST_SENSE_R;
      cfg_rating_q  <= plth_pkg::RST_RATING;
      cfg_bmax_q    <= plth_pkg::RST_BATT_MAX;
      cfg_gain_q    <= plth_pkg::RST_GAIN;
      cfg_ba_q      <= plth_pkg::RST_BATT_ASSERT;
      cfg_br_q      <= plth_pkg::RST_BATT_RELEASE;
      cfg_ra_q      <= plth_pkg::RST_RATED_ASSERT;
      cfg_rr_q      <= plth_pkg::RST_RATED_RELEASE;
    end else begin
      state_q <= state_d;

      // Operation sequencing.
      if (in_xfer) begin
        op_q <= plth_pkg::OP_RATED;
      end else if ((state_q == plth_pkg::ST_WB) && (op_q != plth_pkg::OP_THR_RELEASE)) begin
        op_q <= plth_pkg::op_e'(op_q + 4'd1);
      end

      // Step counter for the multiply and divide phases.
      if ((state_q == plth_pkg::ST_LOAD) ||
          ((state_q == plth_pkg::ST_MUL) &&
           (cnt_q == plth_pkg::CNT_W'(plth_pkg::MUL_CYCLES - 1)))) begin
        cnt_q <= '0;
      end else if ((state_q == plth_pkg::ST_MUL) || (state_q == plth_pkg::ST_DIV)) begin
        cnt_q <= cnt_q + 1'b1;
      end

      // Output slot and throttle level.
      if (out_load) begin
        out_valid_q <= 1'b1;
        throttle_q  <= level_next;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      // Register writes.
      if (cfg_valid_i) begin
        case (cfg_index_i)
          plth_pkg::CFG_SENSE_R:       cfg_sense_r_q <= cfg_data_i[6:0];
          plth_pkg::CFG_RATING:        cfg_rating_q  <= cfg_data_i;
          plth_pkg::CFG_BATT_MAX:      cfg_bmax_q    <= cfg_data_i;
          plth_pkg::CFG_GAIN:          cfg_gain_q    <= cfg_data_i;
          plth_pkg::CFG_BATT_ASSERT:   cfg_ba_q      <= cfg_data_i;
          plth_pkg::CFG_BATT_RELEASE:  cfg_br_q      <= cfg_data_i;
          plth_pkg::CFG_RATED_ASSERT:  cfg_ra_q      <= cfg_data_i;
          plth_pkg::CFG_RATED_RELEASE: cfg_rr_q      <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    // Capture the sample on its transfer.
    if (in_xfer) begin
      in_sense_q <= s_axis_tdata[11:0];
      in_avolt_q <= s_axis_tdata[27:12];
      in_acur_q  <= s_axis_tdata[43:28];
      in_bvolt_q <= s_axis_tdata[59:44];
      in_bcur_q  <= s_axis_tdata[75:60];
      in_soc_q   <= s_axis_tdata[82:76];
      in_bfail_q <= s_axis_tdata[83];
      in_cfail_q <= s_axis_tdata[84];
      in_ac_q    <= s_axis_tdata[85];
      in_bpres_q <= s_axis_tdata[86];
    end

    // Serial unit: load, shift-add multiply, restoring divide.
    case (state_q)
      plth_pkg::ST_LOAD: begin
        work_q   <= '0;
        mcand_q  <= opa;
        mplier_q <= opb;
        dvsr_q   <= opc;
        rem_q    <= '0;
      end
      plth_pkg::ST_MUL: begin
        work_q   <= mul_sum;
        mcand_q  <= {mcand_q[plth_pkg::WORK_W-2:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[plth_pkg::MPLR_W-1:1]};
      end
      plth_pkg::ST_DIV: begin
        rem_q  <= div_ge ? div_diff[plth_pkg::DVSR_W-1:0] : div_shift[plth_pkg::DVSR_W-1:0];
        work_q <= {work_q[plth_pkg::WORK_W-2:0], div_ge};
      end
      default: ;
    endcase

    // Write back the quotient of the finished operation.
    if (state_q == plth_pkg::ST_WB) begin
      case (op_q)
        plth_pkg::OP_RATED:       rated_w_q  <= work_q[12:0];
        plth_pkg::OP_BATT_MW:     batt_mw_q  <= work_q[21:0];
        plth_pkg::OP_BATT_W:      batt_w_q   <= work_q[11:0];
        plth_pkg::OP_SENSE_I:     sense_i_q  <= work_q[16:0];
        plth_pkg::OP_VOLT:        volt_v_q   <= work_q[6:0];
        plth_pkg::OP_ADPT_RAW:    adpt_raw_q <= work_q[22:0];
        plth_pkg::OP_ADPT_MW:     adpt_mw_q  <= work_q[24:0];
        plth_pkg::OP_TOTAL_W:     total_w_q  <= work_q[14:0];
        plth_pkg::OP_THR_ASSERT:  thr_a_q    <= work_q[15:0];
        plth_pkg::OP_THR_RELEASE: thr_r_q    <= thr_add + work_q[15:0];
        default: ;
      endcase
    end

    // Result register.
    if (out_load) begin
      out_throttle_q <= level_next;
      out_action_q   <= action_c;
      out_power_q    <= skip ? 16'd0 : {1'b0, total_w_q};
      out_cle_q      <= in_bpres_q;
    end
  end

`ifndef SYNTHESIS
  // A skipped sample reports no power.
  a_skip_zero_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_action_q == plth_pkg::ACT_SKIP) |-> (out_power_q == 16'd0))
    else $error("skipped sample reports nonzero power");

  // The reported level follows an assert or release command.
  a_level_matches_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && ((out_action_q == plth_pkg::ACT_ASSERT) ||
                    (out_action_q == plth_pkg::ACT_RELEASE))
    |-> (out_throttle_q == (out_action_q == plth_pkg::ACT_ASSERT)))
    else $error("throttle level disagrees with command");

  // An accepted sample starts the sequence at its first operation.
  a_start_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == plth_pkg::ST_LOAD) && (op_q == plth_pkg::OP_RATED))
    else $error("sample transfer did not start the sequence");

  // The partial remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == plth_pkg::ST_DIV) |-> (rem_q < dvsr_q))
    else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire
